// ----- sv/pnf_pkg.sv -----
// ---------------------------------------------------------------------------
// pnf_pkg
// Shared widths, character codes, FNV-1a 64 constants and the fold function
// for the path normalizer and hasher.
// ---------------------------------------------------------------------------
package pnf_pkg;

    localparam int BYTE_W = 8;
    localparam int HASH_W = 64;

    localparam logic [HASH_W-1:0] FNV_OFFSET  = 64'hCBF2_9CE4_8422_2325;
    localparam int                PRIME_SHIFT = 40;
    localparam int                PRIME_LO_W  = 9;
    localparam logic [PRIME_LO_W-1:0] FNV_PRIME_LO = 9'h1B3;

    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFS  = 8'h20;

    typedef struct packed {
        logic take;
        logic tail;
    } pnf_cmd_t;

    typedef struct packed {
        logic need_tail;
        logic last_pend;
        logic out_busy;
    } pnf_status_t;

    // prime = 2^40 + 0x1B3: shift plus a 64x9 product
    function automatic logic [HASH_W-1:0] fnv_fold(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0]            x;
        logic [HASH_W+PRIME_LO_W-1:0] p;
        begin
            x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
            p = x * FNV_PRIME_LO;
            fnv_fold = (x << PRIME_SHIFT) + p[HASH_W-1:0];
        end
    endfunction

endpackage

// ----- sv/pnf_ifs.sv -----
// ---------------------------------------------------------------------------
// pnf channel interfaces
// Valid/ready channels for path bytes and for the resulting identifier.
// ---------------------------------------------------------------------------
interface pnf_path_if
    import pnf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] path_byte;
    logic              has_byte;
    logic              last_item;

    modport source (output valid, output path_byte, output has_byte, output last_item,
                    input ready);
    modport sink   (input valid, input path_byte, input has_byte, input last_item,
                    output ready);
endinterface

interface pnf_id_if
    import pnf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] path_id;

    modport source (output valid, output path_id, input ready);
    modport sink   (input valid, input path_id, output ready);
endinterface

// ----- sv/pnf_ctrl.sv -----
// ---------------------------------------------------------------------------
// pnf_ctrl
// Controller: accepts one request, then enters a tail state when a second
// fold or the identifier output is due.
// ---------------------------------------------------------------------------
module pnf_ctrl
    import pnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pnf_status_t status,
    output pnf_cmd_t    cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_TAIL = 1'b1;

    logic state_reg;
    logic state_next;
    logic tail_go;

    assign in_ready = (state_reg == S_IDLE);
    assign tail_go  = !(status.last_pend && status.out_busy);

    always_comb
    begin
        cmd.take   = 1'b0;
        cmd.tail   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.need_tail)
                    begin
                        state_next = S_TAIL;
                    end
                end
            end
            S_TAIL:
            begin
                if (tail_go)
                begin
                    cmd.tail   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/pnf_dp.sv -----
// ---------------------------------------------------------------------------
// pnf_dp
// Datapath: normalizer flags, byte decode, FNV-1a fold unit, held second
// fold and the identifier output register.
// ---------------------------------------------------------------------------
module pnf_dp
    import pnf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  pnf_cmd_t          cmd,
    output pnf_status_t       status,
    input  logic [BYTE_W-1:0] path_byte,
    input  logic              has_byte,
    input  logic              last_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [HASH_W-1:0] path_id
);

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic              prev_sep_reg;
    logic              raw_ne_reg;
    logic              in_prefix_reg;
    logic              pend_dot_reg;
    logic              pend_sep_reg;
    logic              prev_sep_next;
    logic              raw_ne_next;
    logic              in_prefix_next;
    logic              pend_dot_next;
    logic              pend_sep_next;

    logic [BYTE_W-1:0] b1_reg;
    logic              e1_reg;
    logic              last_reg;
    logic              out_valid_reg;
    logic [HASH_W-1:0] out_reg;

    logic [BYTE_W-1:0] lc;
    logic              is_sep;
    logic [BYTE_W-1:0] b0;
    logic              e0;
    logic [BYTE_W-1:0] b1;
    logic              e1;
    logic [BYTE_W-1:0] fold_byte;
    logic [HASH_W-1:0] fold_res;
    logic [HASH_W-1:0] tail_hash;

    assign is_sep = (path_byte == CH_BSLASH) || (path_byte == CH_SLASH);
    assign lc     = ((path_byte >= CH_UP_A) && (path_byte <= CH_UP_Z)) ?
                    path_byte + CASE_OFS : path_byte;

    always_comb
    begin
        prev_sep_next  = prev_sep_reg;
        raw_ne_next    = raw_ne_reg;
        in_prefix_next = in_prefix_reg;
        pend_dot_next  = pend_dot_reg;
        pend_sep_next  = pend_sep_reg;
        b0 = lc;
        e0 = 1'b0;
        b1 = lc;
        e1 = 1'b0;
        if (has_byte)
        begin
            if (is_sep)
            begin
                if (!prev_sep_reg && raw_ne_reg)
                begin
                    if (in_prefix_reg)
                    begin
                        pend_dot_next = 1'b0;
                    end
                    else
                    begin
                        pend_sep_next = 1'b1;
                    end
                end
                prev_sep_next = 1'b1;
            end
            else
            begin
                prev_sep_next = 1'b0;
                raw_ne_next   = 1'b1;
                if (in_prefix_reg)
                begin
                    if (pend_dot_reg)
                    begin
                        b0 = CH_DOT;
                        e0 = 1'b1;
                        e1 = 1'b1;
                        pend_dot_next  = 1'b0;
                        in_prefix_next = 1'b0;
                    end
                    else if (lc == CH_DOT)
                    begin
                        pend_dot_next = 1'b1;
                    end
                    else
                    begin
                        e0 = 1'b1;
                        in_prefix_next = 1'b0;
                    end
                end
                else
                begin
                    if (pend_sep_reg)
                    begin
                        b0 = CH_SLASH;
                        e0 = 1'b1;
                        e1 = 1'b1;
                        pend_sep_next = 1'b0;
                    end
                    else
                    begin
                        e0 = 1'b1;
                    end
                end
            end
        end
        // flush a held dot at end of path
        if (last_item && pend_dot_next)
        begin
            b1 = CH_DOT;
            e1 = 1'b1;
        end
    end

    assign fold_byte = cmd.tail ? b1_reg : b0;
    assign fold_res  = fnv_fold(hash_reg, fold_byte);
    assign tail_hash = e1_reg ? fold_res : hash_reg;

    always_comb
    begin
        hash_next = hash_reg;
        if (cmd.take && e0)
        begin
            hash_next = fold_res;
        end
        else if (cmd.tail)
        begin
            hash_next = last_reg ? FNV_OFFSET : tail_hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= FNV_OFFSET;
            prev_sep_reg  <= 1'b0;
            raw_ne_reg    <= 1'b0;
            in_prefix_reg <= 1'b1;
            pend_dot_reg  <= 1'b0;
            pend_sep_reg  <= 1'b0;
            e1_reg        <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg <= hash_next;
            if (cmd.take)
            begin
                prev_sep_reg  <= prev_sep_next;
                raw_ne_reg    <= raw_ne_next;
                in_prefix_reg <= in_prefix_next;
                pend_dot_reg  <= pend_dot_next;
                pend_sep_reg  <= pend_sep_next;
                e1_reg        <= e1;
                last_reg      <= last_item;
            end
            else if (cmd.tail && last_reg)
            begin
                prev_sep_reg  <= 1'b0;
                raw_ne_reg    <= 1'b0;
                in_prefix_reg <= 1'b1;
                pend_dot_reg  <= 1'b0;
                pend_sep_reg  <= 1'b0;
            end
            if (cmd.tail && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            b1_reg <= b1;
        end
        if (cmd.tail && last_reg)
        begin
            out_reg <= (tail_hash == '0) ? {{(HASH_W-1){1'b0}}, 1'b1} : tail_hash;
        end
    end

    assign status.need_tail = e1 || last_item;
    assign status.last_pend = last_reg;
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign path_id   = out_reg;

endmodule

// ----- sv/path_normalize_fnv1a64_id.sv -----
// ---------------------------------------------------------------------------
// path_normalize_fnv1a64_id
// Streaming path normalizer with FNV-1a 64 identifier output.
//
//   channel   dir   payload                          accepted when
//   path_chan sink  path_byte, has_byte, last_item   valid && ready
//   id_chan   src   path_id                          valid && ready
//
// A request that releases a held slash or dot together with its own byte, or
// that ends the path, also passes through the tail state; the single fold
// unit (shift plus 64x9 product) handles one byte per cycle unless stalled.
// The identifier sits in an output register; new requests are taken while
// it waits, and only the tail cycle of the next last request stalls on it.
// Reset restores the offset basis and the prefix state at once.
// ---------------------------------------------------------------------------
module path_normalize_fnv1a64_id
    import pnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pnf_path_if.sink    path_chan,
    pnf_id_if.source    id_chan
);

    pnf_cmd_t    cmd;
    pnf_status_t status;

    pnf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (path_chan.valid),
        .in_ready (path_chan.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pnf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .path_byte (path_chan.path_byte),
        .has_byte  (path_chan.has_byte),
        .last_item (path_chan.last_item),
        .out_valid (id_chan.valid),
        .out_ready (id_chan.ready),
        .path_id   (id_chan.path_id)
    );

    a_last_has_tail: assert property (@(posedge clk) disable iff (!rst_n)
        path_chan.valid && path_chan.ready && path_chan.last_item |=> !path_chan.ready)
        else $error("last request did not enter tail cycle");

    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        id_chan.valid |-> id_chan.path_id != '0)
        else $error("identifier is zero");

    a_id_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(id_chan.valid) |-> $past(!path_chan.ready))
        else $error("identifier loaded outside a tail cycle");

endmodule
